// ===== src/ffd_pkg.sv =====
// ----------------------------------------------------------------------------
// ffd_pkg
// shared constants, codes and handshake structs of the fixed frame deframer
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int FRAME_LEN_DEF = 16;
  localparam int HDR_LEN       = 2;
  localparam int NOT_PAYLOAD   = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TAIL = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;

  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_TAIL       = 2'd2;

  localparam logic [7:0] HDR_FIRST_RST  = 8'd170;
  localparam logic [7:0] HDR_SECOND_RST = 8'd85;
  localparam logic [7:0] TAIL_RST       = 8'd187;

  typedef struct packed {
    logic       push;
    logic [1:0] status;
  } front_ev_t;

  typedef struct packed {
    logic       not_empty;
    logic       full;
    logic [1:0] status;
  } q_stat_t;

endpackage

// ===== src/ffd_front.sv =====
// ----------------------------------------------------------------------------
// ffd_front
// header hunt, frame collection, payload write and frame check
// ----------------------------------------------------------------------------
module ffd_front #(
  parameter int FRAME_LEN = ffd_pkg::FRAME_LEN_DEF,
  localparam int PLEN = FRAME_LEN - ffd_pkg::NOT_PAYLOAD,
  localparam int IW = (PLEN > 1) ? $clog2(PLEN) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic [7:0]          in_data,
  output logic                in_ready,
  input  ffd_pkg::q_stat_t    qs,
  output ffd_pkg::front_ev_t  ev,
  output logic                wr_en,
  output logic [IW-1:0]       wr_idx,
  output logic [7:0]          wr_data
);

  localparam int CW = $clog2(FRAME_LEN);
  localparam logic [CW-1:0] LAST_POS = CW'(FRAME_LEN - 1);
  localparam logic [CW-1:0] CSUM_POS = CW'(FRAME_LEN - 2);

  logic [7:0]    hdr_first;
  logic [7:0]    hdr_second;
  logic [7:0]    tail_value;
  logic          collecting;
  logic          collecting_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    sum;
  logic [7:0]    sum_next;
  logic [7:0]    csum;
  logic [7:0]    csum_next;
  logic [CW-1:0] pidx;
  logic          accept;

  assign in_ready = ~qs.full;
  assign accept   = in_valid & in_ready;
  assign pidx     = count - CW'(ffd_pkg::HDR_LEN);
  assign wr_idx   = pidx[IW-1:0];
  assign wr_data  = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= ffd_pkg::HDR_FIRST_RST;
      hdr_second <= ffd_pkg::HDR_SECOND_RST;
      tail_value <= ffd_pkg::TAIL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffd_pkg::REG_HDR_FIRST:  hdr_first  <= cfg_data;
        ffd_pkg::REG_HDR_SECOND: hdr_second <= cfg_data;
        ffd_pkg::REG_TAIL:       tail_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    collecting_next = collecting;
    count_next      = count;
    sum_next        = sum;
    csum_next       = csum;
    ev              = '0;
    wr_en           = 1'b0;
    if (accept) begin
      if (!collecting) begin
        if (count == '0 && in_data == hdr_first) begin
          count_next = CW'(1);
        end else if (count == CW'(1) && in_data == hdr_second) begin
          count_next      = CW'(ffd_pkg::HDR_LEN);
          collecting_next = 1'b1;
          sum_next        = '0;
        end else begin
          count_next = '0;
        end
      end else if (count == LAST_POS) begin
        ev.push = 1'b1;
        if (in_data != tail_value) begin
          ev.status = ffd_pkg::ST_BAD_TAIL;
        end else if (sum != csum) begin
          ev.status = ffd_pkg::ST_BAD_SUM;
        end else begin
          ev.status = ffd_pkg::ST_OK;
        end
        collecting_next = 1'b0;
        count_next      = '0;
        sum_next        = '0;
      end else begin
        count_next = count + CW'(1);
        if (count == CSUM_POS) begin
          csum_next = in_data;
        end else begin
          wr_en    = 1'b1;
          sum_next = sum + in_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      count      <= '0;
      sum        <= '0;
    end else begin
      collecting <= collecting_next;
      count      <= count_next;
      sum        <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    csum <= csum_next;
  end

endmodule

// ===== src/ffd_buf.sv =====
// ----------------------------------------------------------------------------
// ffd_buf
// two-bank payload store and two-entry frame status queue
// ----------------------------------------------------------------------------
module ffd_buf #(
  parameter int FRAME_LEN = ffd_pkg::FRAME_LEN_DEF,
  localparam int PLEN = FRAME_LEN - ffd_pkg::NOT_PAYLOAD,
  localparam int IW = (PLEN > 1) ? $clog2(PLEN) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  ffd_pkg::front_ev_t ev,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_idx,
  input  logic [7:0]         wr_data,
  input  logic               pop,
  input  logic [IW-1:0]      rd_idx,
  output logic [7:0]         rd_data,
  output ffd_pkg::q_stat_t   qs
);

  logic [7:0] mem [2**(IW+1)];
  logic [1:0] status_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_ptr, wr_idx}] <= wr_data;
    end
    rd_data <= mem[{rd_ptr, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (ev.push) begin
      status_q[wr_ptr] <= ev.status;
    end
  end

  always_comb begin
    case ({ev.push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (ev.push) wr_ptr <= ~wr_ptr;
      if (pop)     rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  assign qs.not_empty = (count != 2'd0);
  assign qs.full      = (count == 2'd2);
  assign qs.status    = status_q[rd_ptr];

endmodule

// ===== src/ffd_back.sv =====
// ----------------------------------------------------------------------------
// ffd_back
// result sequencer: status result or payload run into an output register
// ----------------------------------------------------------------------------
module ffd_back #(
  parameter int FRAME_LEN = ffd_pkg::FRAME_LEN_DEF,
  localparam int PLEN = FRAME_LEN - ffd_pkg::NOT_PAYLOAD,
  localparam int IW = (PLEN > 1) ? $clog2(PLEN) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  ffd_pkg::q_stat_t qs,
  output logic             pop,
  output logic [IW-1:0]    rd_idx,
  input  logic [7:0]       rd_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_data,
  output logic [4:0]       out_index,
  output logic             out_last,
  output logic [1:0]       out_status
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PLEN - 1);

  logic          state;
  logic          state_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic          load;
  logic          free;
  logic          is_last;
  logic          valid_next;
  logic [7:0]    data_next;
  logic [IW-1:0] oidx_next;
  logic          last_next;
  logic [1:0]    status_next;
  logic [IW-1:0] oidx;

  assign free      = ~out_valid | out_ready;
  assign is_last   = (idx == LAST_IDX);
  assign out_index = 5'(oidx);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pop         = 1'b0;
    load        = 1'b0;
    rd_idx      = '0;
    data_next   = out_data;
    oidx_next   = oidx;
    last_next   = out_last;
    status_next = out_status;
    case (state)
      B_IDLE: begin
        if (qs.not_empty && free) begin
          if (qs.status != ffd_pkg::ST_OK) begin
            load        = 1'b1;
            pop         = 1'b1;
            data_next   = '0;
            oidx_next   = '0;
            last_next   = 1'b1;
            status_next = qs.status;
          end else begin
            state_next = B_RUN;
            idx_next   = '0;
          end
        end
      end
      B_RUN: begin
        rd_idx = idx;
        if (free) begin
          load        = 1'b1;
          data_next   = rd_data;
          oidx_next   = idx;
          last_next   = is_last;
          status_next = ffd_pkg::ST_OK;
          if (is_last) begin
            pop        = 1'b1;
            state_next = B_IDLE;
          end else begin
            idx_next = idx + IW'(1);
            rd_idx   = idx + IW'(1);
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
    valid_next = load | (out_valid & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data   <= data_next;
    oidx       <= oidx_next;
    out_last   <= last_next;
    out_status <= status_next;
  end

endmodule

// ===== src/fixed_frame_deframer_sum_check.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_deframer_sum_check
// fixed-length frame deframer with tail and additive checksum check
// ----------------------------------------------------------------------------
// result path: status queue -> output register; payload adds store read first
// throughput: one input byte per cycle, stalled only while two finished
//   frames wait in the two-entry status queue; payload leaves at one byte per
//   ready cycle from the two-bank store, set by its single registered read port
// reset: synchronous, clears hunt state, queue and output valid; store uncleared
// ----------------------------------------------------------------------------
module fixed_frame_deframer_sum_check #(
  parameter int FRAME_LEN = ffd_pkg::FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [12:8] byte_index
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

  localparam int PLEN = FRAME_LEN - ffd_pkg::NOT_PAYLOAD;
  localparam int IW = (PLEN > 1) ? $clog2(PLEN) : 1;

  ffd_pkg::front_ev_t ev;
  ffd_pkg::q_stat_t   qs;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic [7:0]         wr_data;
  logic               pop;
  logic [IW-1:0]      rd_idx;
  logic [7:0]         rd_data;
  logic [7:0]         out_data;
  logic [4:0]         out_index;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {3'b000, out_index, out_data};

  ffd_front #(.FRAME_LEN(FRAME_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .qs        (qs),
    .ev        (ev),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data)
  );

  ffd_buf #(.FRAME_LEN(FRAME_LEN)) u_buf (
    .clk     (clk),
    .rst     (rst),
    .ev      (ev),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .qs      (qs)
  );

  ffd_back #(.FRAME_LEN(FRAME_LEN)) u_back (
    .clk        (clk),
    .rst        (rst),
    .qs         (qs),
    .pop        (pop),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data),
    .out_index  (out_index),
    .out_last   (m_axis_tlast),
    .out_status (m_axis_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    ev.push |-> !qs.full)
    else $error("frame pushed into full status queue");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ffd_pkg::ST_OK) |->
      (m_axis_tlast && m_axis_tdata == 16'd0))
    else $error("reject result not a single zero last transfer");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-length frame deframer. A scoreboard
// tracks the hunt state, running payload sum and header/tail settings and
// predicts each payload run or reject status. It covers a directed header
// corner case, then random well-formed, corrupted and cut frames mixed
// with line noise, under several sender/receiver idle mixes, five register
// settings and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAME_LEN   = ffd_pkg::FRAME_LEN_DEF;
  localparam int PAYLOAD_LEN = FRAME_LEN - ffd_pkg::NOT_PAYLOAD;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 10;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {FR_GOOD, FR_BAD_TAIL, FR_BAD_SUM, FR_BAD_BOTH, FR_CUT_HEADER} frame_kind_t;

  typedef struct {
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
    logic [1:0] status;
  } frame_result_t;

  class deframe_scoreboard;
    logic [7:0]    hdr_first  = ffd_pkg::HDR_FIRST_RST;
    logic [7:0]    hdr_second = ffd_pkg::HDR_SECOND_RST;
    logic [7:0]    tail_val   = ffd_pkg::TAIL_RST;
    bit            collecting = 0;
    int            count      = 0;
    logic [7:0]    payload_sum = 8'd0;
    logic [7:0]    held [FRAME_LEN];
    frame_result_t pending_results [$];
    int            errors = 0;
    int            results_seen = 0;
    int            n_ok = 0;
    int            n_bad_tail = 0;
    int            n_bad_sum = 0;

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        ffd_pkg::REG_HDR_FIRST:  hdr_first  = value;
        ffd_pkg::REG_HDR_SECOND: hdr_second = value;
        ffd_pkg::REG_TAIL:       tail_val   = value;
        default: ;
      endcase
    endfunction

    function void push_result(logic [7:0] d, int i, bit lst, logic [1:0] st);
      frame_result_t r;
      r.data = d;
      r.idx = 5'(i);
      r.last = lst;
      r.status = st;
      pending_results.push_back(r);
    endfunction

    function void take_rx_byte(logic [7:0] b);
      if (!collecting) begin
        if (count == 0 && b == hdr_first) count = 1;
        else if (count == 1 && b == hdr_second) begin
          count = ffd_pkg::HDR_LEN;
          payload_sum = 8'd0;
          collecting = 1;
        end else count = 0;
        return;
      end
      held[count] = b;
      if (count >= ffd_pkg::HDR_LEN && count < FRAME_LEN - 2)
        payload_sum = payload_sum + b;
      count++;
      if (count >= FRAME_LEN) begin
        if (held[FRAME_LEN-1] != tail_val) begin
          push_result(8'd0, 0, 1'b1, ffd_pkg::ST_BAD_TAIL);
          n_bad_tail++;
        end else if (payload_sum != held[FRAME_LEN-2]) begin
          push_result(8'd0, 0, 1'b1, ffd_pkg::ST_BAD_SUM);
          n_bad_sum++;
        end else begin
          for (int i = 0; i < PAYLOAD_LEN; i++)
            push_result(held[ffd_pkg::HDR_LEN+i], i, i == PAYLOAD_LEN - 1, ffd_pkg::ST_OK);
          n_ok++;
        end
        count = 0;
        payload_sum = 8'd0;
        collecting = 0;
      end
    endfunction

    function void match_output(logic [15:0] tdata, logic tlast, logic [1:0] tuser);
      frame_result_t r;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: byte %h index %0d last %b status %0d",
                   tdata[7:0], tdata[12:8], tlast, tuser);
        return;
      end
      r = pending_results.pop_front();
      if (tdata !== {3'b000, r.idx, r.data} || tlast !== r.last || tuser !== r.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp byte %h idx %0d last %b st %0d / got tdata %h last %b st %0d",
                   r.data, r.idx, r.last, r.status, tdata, tlast, tuser);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  deframe_scoreboard sb = new();

  int         src_idle_pct;
  int         snk_stall_pct;
  int         hold_left;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         framed_bytes;
  logic [7:0] payload_buf [PAYLOAD_LEN];

  fixed_frame_deframer_sum_check dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("[fixed_frame_deframer_sum_check] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.match_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // entered and left at a falling edge; tvalid stays up for a following transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] tl);
    write_reg(ffd_pkg::REG_HDR_FIRST, hf);
    write_reg(ffd_pkg::REG_HDR_SECOND, hs);
    write_reg(ffd_pkg::REG_TAIL, tl);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] csum;
    logic [7:0] tl;
    logic [7:0] flip;
    csum = 8'd0;
    for (int i = 0; i < PAYLOAD_LEN; i++) csum = csum + payload_buf[i];
    flip = 8'($urandom_range(1, 255));
    tl = sb.tail_val;
    if (kind == FR_BAD_TAIL || kind == FR_BAD_BOTH) tl = tl ^ flip;
    if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH) csum = csum ^ flip;
    send_byte(sb.hdr_first);
    if (kind == FR_CUT_HEADER) begin
      // wrong second header byte, which may equal the first header value
      send_byte(sb.hdr_second ^ flip);
      framed_bytes += 2;
      return;
    end
    send_byte(sb.hdr_second);
    for (int i = 0; i < PAYLOAD_LEN; i++) send_byte(payload_buf[i]);
    send_byte(csum);
    send_byte(tl);
    framed_bytes += FRAME_LEN;
  endtask

  task automatic fill_random_payload();
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case ($urandom_range(0, 15))
        0:       payload_buf[i] = sb.hdr_first;
        1:       payload_buf[i] = sb.hdr_second;
        2:       payload_buf[i] = sb.tail_val;
        default: payload_buf[i] = 8'($urandom);
      endcase
    end
  endtask

  task automatic run_random(input int n_items);
    int          pick;
    frame_kind_t kind;
    framed_bytes = 0;
    while (framed_bytes < n_items) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      pick = $urandom_range(0, 8);
      if (pick <= 4) kind = FR_GOOD;
      else if (pick == 5) kind = FR_BAD_TAIL;
      else if (pick == 6) kind = FR_BAD_SUM;
      else if (pick == 7) kind = FR_BAD_BOTH;
      else kind = FR_CUT_HEADER;
      fill_random_payload();
      send_frame(kind);
    end
  endtask

  // bring the hunt state back to idle, then wait for all results
  task automatic drain(input int settle);
    while (sb.collecting) send_byte(8'($urandom));
    if (sb.count == 1) send_byte(sb.hdr_second ^ 8'h01);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin
    logic [7:0] rnd;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = ffd_pkg::REG_HDR_FIRST;
    cfg_data = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings; repeated first header is dropped as a wrong second header
    send_byte(ffd_pkg::HDR_FIRST_RST);
    send_byte(ffd_pkg::HDR_FIRST_RST);
    send_byte(ffd_pkg::HDR_SECOND_RST);
    payload_buf = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h80,
                    8'h01, 8'h7F, 8'hBB, 8'hAA, 8'h55, 8'hFE};
    send_frame(FR_GOOD);
    drain(SETTLE);

    set_config(8'h00, 8'hFF, 8'h00);
    run_random(45);
    drain(SETTLE);

    src_idle_pct = 49;
    set_config(8'hFF, 8'h00, 8'hFF);
    run_random(45);
    drain(SETTLE);

    src_idle_pct = 0;
    snk_stall_pct = 49;
    rnd = 8'($urandom);
    set_config(rnd, rnd, 8'($urandom));
    run_random(45);
    drain(SETTLE);

    src_idle_pct = 35;
    snk_stall_pct = 35;
    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    run_random(45);
    drain(SETTLE);

    // long output hold-off while good frames keep coming
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_config(ffd_pkg::HDR_FIRST_RST, ffd_pkg::HDR_SECOND_RST, ffd_pkg::TAIL_RST);
    hold_left = 300;
    repeat (5) begin
      fill_random_payload();
      send_frame(FR_GOOD);
    end
    drain(2 * SETTLE);

    $display("%0d bytes sent under five register settings and idle mixes, one long hold-off",
             bytes_sent);
    $display("frames: %0d accepted, %0d bad tail, %0d bad checksum; %0d outputs, %0d mismatches",
             sb.n_ok, sb.n_bad_tail, sb.n_bad_sum, sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[fixed_frame_deframer_sum_check] OK");
    end else begin
      $display("[fixed_frame_deframer_sum_check] ERROR");
    end
    $finish;
  end

endmodule
